/* design/sdb_pkg.sv */
package sdb_pkg;

    // Field widths fixed by the item formats
    localparam int IN_NUM_W  = 32;
    localparam int IN_EXP_W  = 5;
    localparam int Z_W       = 64;
    localparam int OUT_EXP_W = 5;

    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_STAR   = 2'd1,
        KIND_SWITCH = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [IN_NUM_W-1:0] x_num;
        logic [IN_EXP_W-1:0]        x_den_exp;
        logic signed [IN_NUM_W-1:0] y_num;
        logic [IN_EXP_W-1:0]        y_den_exp;
    } in_item_t;

    typedef struct packed {
        kind_t                 kind;
        logic signed [Z_W-1:0] z_num;
        logic [OUT_EXP_W-1:0]  z_den_exp;
    } out_item_t;

    // Control that travels alongside each pipeline stage
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  zero;      // result numerator and exponent forced to zero
        logic  mirrored;  // magnitude form; negate at the end
    } ctl_t;

endpackage

/* design/sdb_align.sv */
module sdb_align #(
    parameter int NUM_BITS    = 32,
    parameter int MAX_DEN_EXP = 30,
    localparam int AW = NUM_BITS + MAX_DEN_EXP,
    localparam int EW = $clog2(MAX_DEN_EXP + 2)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  sdb_pkg::in_item_t      item,
    output sdb_pkg::ctl_t          ctl,
    output logic signed [AW-1:0]   a,
    output logic signed [AW-1:0]   b,
    output logic [EW-1:0]          e
);

    logic [EW-1:0]        ea;
    logic [EW-1:0]        eb;
    logic [EW-1:0]        e_next;
    logic signed [AW-1:0] xs;
    logic signed [AW-1:0] ys;
    logic signed [AW-1:0] a_next;
    logic signed [AW-1:0] b_next;
    sdb_pkg::ctl_t        ctl_next;

    sdb_pkg::ctl_t        ctl_reg;
    logic signed [AW-1:0] a_reg;
    logic signed [AW-1:0] b_reg;
    logic [EW-1:0]        e_reg;

    // Saturate exponents, sign-extend numerators, align to the larger exponent
    always_comb
    begin
        ea = (item.x_den_exp > sdb_pkg::IN_EXP_W'(MAX_DEN_EXP)) ?
             EW'(MAX_DEN_EXP) : EW'(item.x_den_exp);
        eb = (item.y_den_exp > sdb_pkg::IN_EXP_W'(MAX_DEN_EXP)) ?
             EW'(MAX_DEN_EXP) : EW'(item.y_den_exp);
        e_next = (ea > eb) ? ea : eb;
        xs = {{MAX_DEN_EXP{item.x_num[NUM_BITS-1]}}, item.x_num[NUM_BITS-1:0]};
        ys = {{MAX_DEN_EXP{item.y_num[NUM_BITS-1]}}, item.y_num[NUM_BITS-1:0]};
        a_next = xs << (e_next - ea);
        b_next = ys << (e_next - eb);
        ctl_next          = '0;
        ctl_next.valid    = start;
        ctl_next.kind     = sdb_pkg::KIND_NUMBER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        e_reg <= e_next;
    end

    assign ctl = ctl_reg;
    assign a   = a_reg;
    assign b   = b_reg;
    assign e   = e_reg;

endmodule

/* design/sdb_classify.sv */
module sdb_classify #(
    parameter int NUM_BITS    = 32,
    parameter int MAX_DEN_EXP = 30,
    localparam int AW = NUM_BITS + MAX_DEN_EXP,
    localparam int UW = AW + 1,
    localparam int EW = $clog2(MAX_DEN_EXP + 2)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdb_pkg::ctl_t        ctl_in,
    input  logic signed [AW-1:0] a,
    input  logic signed [AW-1:0] b,
    input  logic [EW-1:0]        e_in,
    output sdb_pkg::ctl_t        ctl,
    output logic [UW-1:0]        lo,
    output logic [UW-1:0]        h,
    output logic [EW-1:0]        e
);

    logic [UW-1:0]  a_w;
    logic [UW-1:0]  b_w;
    logic           straddle;
    sdb_pkg::ctl_t  ctl2_next;
    logic [UW-1:0]  lo2_next;
    logic [UW-1:0]  hi2_next;

    sdb_pkg::ctl_t  ctl2_reg;
    logic [UW-1:0]  lo2_reg;
    logic [UW-1:0]  hi2_reg;
    logic [EW-1:0]  e2_reg;

    logic           adj;
    logic [UW-1:0]  lo3_next;
    logic [UW-1:0]  h3_next;
    logic [EW-1:0]  e3_next;

    sdb_pkg::ctl_t  ctl3_reg;
    logic [UW-1:0]  lo3_reg;
    logic [UW-1:0]  h3_reg;
    logic [EW-1:0]  e3_reg;

    // Classify the pair and fold non-positive intervals to magnitudes
    always_comb
    begin
        a_w      = {a[AW-1], a};
        b_w      = {b[AW-1], b};
        straddle = a[AW-1] && !b[AW-1] && (b != '0);
        ctl2_next          = ctl_in;
        ctl2_next.mirrored = a[AW-1];
        ctl2_next.zero     = 1'b0;
        priority if (a > b)
        begin
            ctl2_next.kind = sdb_pkg::KIND_SWITCH;
            ctl2_next.zero = 1'b1;
        end
        else if (straddle)
        begin
            ctl2_next.kind = sdb_pkg::KIND_NUMBER;
            ctl2_next.zero = 1'b1;
        end
        else if (a == b)
        begin
            ctl2_next.kind = sdb_pkg::KIND_STAR;
        end
        else
        begin
            ctl2_next.kind = sdb_pkg::KIND_NUMBER;
        end
        lo2_next = a[AW-1] ? (-b_w) : a_w;
        hi2_next = a[AW-1] ? (-a_w) : b_w;
    end

    // Adjacent ends: double both and add an exponent bit; keep the upper end inclusive
    always_comb
    begin
        adj = (ctl2_reg.kind == sdb_pkg::KIND_NUMBER) && !ctl2_reg.zero &&
              ((hi2_reg - lo2_reg) == UW'(1));
        lo3_next = adj ? (lo2_reg << 1) : lo2_reg;
        h3_next  = adj ? ((lo2_reg << 1) | UW'(1)) : (hi2_reg - UW'(1));
        e3_next  = adj ? (e2_reg + EW'(1)) : e2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl2_next;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo2_reg <= lo2_next;
        hi2_reg <= hi2_next;
        e2_reg  <= e_in;
        lo3_reg <= lo3_next;
        h3_reg  <= h3_next;
        e3_reg  <= e3_next;
    end

    assign ctl = ctl3_reg;
    assign lo  = lo3_reg;
    assign h   = h3_reg;
    assign e   = e3_reg;

endmodule

/* design/sdb_search.sv */
module sdb_search #(
    parameter int NUM_BITS    = 32,
    parameter int MAX_DEN_EXP = 30,
    localparam int UW = NUM_BITS + MAX_DEN_EXP + 1,
    localparam int KW = $clog2(UW),
    localparam int EW = $clog2(MAX_DEN_EXP + 2)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sdb_pkg::ctl_t ctl_in,
    input  logic [UW-1:0] lo_in,
    input  logic [UW-1:0] h_in,
    input  logic [EW-1:0] e_in,
    output sdb_pkg::ctl_t ctl,
    output logic [UW-1:0] zn,
    output logic [EW-1:0] e
);

    logic [UW-1:0]  diff;
    logic [KW-1:0]  p;
    logic [KW-1:0]  k_next;

    sdb_pkg::ctl_t  ctl4_reg;
    logic [UW-1:0]  lo4_reg;
    logic [KW-1:0]  k4_reg;
    logic [EW-1:0]  e4_reg;

    logic [UW-1:0]  mask;
    logic [UW-1:0]  zn_next;

    sdb_pkg::ctl_t  ctl5_reg;
    logic [UW-1:0]  zn5_reg;
    logic [EW-1:0]  e5_reg;

    // Coarsest step: highest bit where lo and the inclusive upper end differ, capped at e
    always_comb
    begin
        diff = lo_in ^ h_in;
        p    = '0;
        for (int i = 0; i < UW; i++)
        begin
            if (diff[i])
            begin
                p = KW'(i);
            end
        end
        k_next = (KW'(e_in) < p) ? KW'(e_in) : p;
    end

    // Next multiple of the step above lo; a starred value passes lo through unchanged
    always_comb
    begin
        mask    = ~({UW{1'b1}} << k4_reg);
        zn_next = (ctl4_reg.kind == sdb_pkg::KIND_STAR) ? lo4_reg : ((lo4_reg | mask) + UW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else
        begin
            ctl4_reg <= ctl_in;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo4_reg <= lo_in;
        k4_reg  <= k_next;
        e4_reg  <= e_in;
        zn5_reg <= zn_next;
        e5_reg  <= e4_reg;
    end

    assign ctl = ctl5_reg;
    assign zn  = zn5_reg;
    assign e   = e5_reg;

endmodule

/* design/sdb_reduce.sv */
module sdb_reduce #(
    parameter int NUM_BITS    = 32,
    parameter int MAX_DEN_EXP = 30,
    localparam int UW = NUM_BITS + MAX_DEN_EXP + 1,
    localparam int KW = $clog2(UW),
    localparam int EW = $clog2(MAX_DEN_EXP + 2)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sdb_pkg::ctl_t      ctl_in,
    input  logic [UW-1:0]      zn_in,
    input  logic [EW-1:0]      e_in,
    output logic               done,
    output sdb_pkg::out_item_t result
);

    logic [KW-1:0]      tz;
    logic [EW-1:0]      s_next;

    sdb_pkg::ctl_t      ctl6_reg;
    logic [UW-1:0]      zn6_reg;
    logic [EW-1:0]      s6_reg;
    logic [EW-1:0]      e6_reg;

    logic [UW-1:0]                 zs;
    logic [sdb_pkg::Z_W-1:0]       z64;
    sdb_pkg::out_item_t            result_next;

    logic                          done_reg;
    sdb_pkg::out_item_t            result_reg;

    // Trailing zeros, capped by the exponent; a starred value is left as is
    always_comb
    begin
        tz = '0;
        for (int i = UW - 1; i >= 0; i--)
        begin
            if (zn_in[i])
            begin
                tz = KW'(i);
            end
        end
        if (ctl_in.kind == sdb_pkg::KIND_STAR)
        begin
            s_next = '0;
        end
        else
        begin
            s_next = (KW'(e_in) < tz) ? e_in : EW'(tz);
        end
    end

    // Drop the common factor and restore the sign, or force a zero result
    always_comb
    begin
        zs  = zn6_reg >> s6_reg;
        z64 = sdb_pkg::Z_W'(zs);
        result_next.kind = ctl6_reg.kind;
        if (ctl6_reg.zero)
        begin
            result_next.z_num     = '0;
            result_next.z_den_exp = '0;
        end
        else
        begin
            result_next.z_num     = ctl6_reg.mirrored ? -z64 : z64;
            result_next.z_den_exp = sdb_pkg::OUT_EXP_W'(e6_reg - s6_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl6_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl6_reg <= ctl_in;
            done_reg <= ctl6_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zn6_reg    <= zn_in;
        s6_reg     <= s_next;
        e6_reg     <= e_in;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* design/simplest_dyadic_between.sv */
// Throughput: one item per cycle, seven items in flight in the seven-stage pipeline.
// busy is always low: every stage advances each cycle and nothing is ever held.
// Each result is shown for one cycle only; the receiver cannot stall the pipeline.
// Reset (rst_n, asynchronous, active low) clears the valid bits of every stage.
module simplest_dyadic_between #(
    parameter int NUM_BITS    = 32,
    parameter int MAX_DEN_EXP = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sdb_pkg::in_item_t  item,
    output logic               done,
    output sdb_pkg::out_item_t result
);

    localparam int AW = NUM_BITS + MAX_DEN_EXP;
    localparam int UW = AW + 1;
    localparam int EW = $clog2(MAX_DEN_EXP + 2);

    // Stage 1 -> 2: aligned signed numerators at the common exponent
    sdb_pkg::ctl_t        ctl_al;
    logic signed [AW-1:0] a_al;
    logic signed [AW-1:0] b_al;
    logic [EW-1:0]        e_al;

    // Stage 3 -> 4: magnitudes, lower end exclusive, upper end inclusive
    sdb_pkg::ctl_t        ctl_cl;
    logic [UW-1:0]        lo_cl;
    logic [UW-1:0]        h_cl;
    logic [EW-1:0]        e_cl;

    // Stage 5 -> 6: unreduced numerator of the answer
    sdb_pkg::ctl_t        ctl_sr;
    logic [UW-1:0]        zn_sr;
    logic [EW-1:0]        e_sr;

    // Nothing downstream can hold a transfer off, so an item is always taken
    assign busy = 1'b0;

    // Stage 1: saturate exponents and align both numerators
    sdb_align #(
        .NUM_BITS    (NUM_BITS),
        .MAX_DEN_EXP (MAX_DEN_EXP)
    ) u_align (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !busy),
        .item  (item),
        .ctl   (ctl_al),
        .a     (a_al),
        .b     (b_al),
        .e     (e_al)
    );

    // Stages 2-3: classify, mirror to the positive side, widen adjacent ends
    sdb_classify #(
        .NUM_BITS    (NUM_BITS),
        .MAX_DEN_EXP (MAX_DEN_EXP)
    ) u_classify (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (ctl_al),
        .a      (a_al),
        .b      (b_al),
        .e_in   (e_al),
        .ctl    (ctl_cl),
        .lo     (lo_cl),
        .h      (h_cl),
        .e      (e_cl)
    );

    // Stages 4-5: pick the coarsest power-of-two step that lands inside, then round lo up
    sdb_search #(
        .NUM_BITS    (NUM_BITS),
        .MAX_DEN_EXP (MAX_DEN_EXP)
    ) u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (ctl_cl),
        .lo_in  (lo_cl),
        .h_in   (h_cl),
        .e_in   (e_cl),
        .ctl    (ctl_sr),
        .zn     (zn_sr),
        .e      (e_sr)
    );

    // Stages 6-7: reduce to lowest terms and restore the sign
    sdb_reduce #(
        .NUM_BITS    (NUM_BITS),
        .MAX_DEN_EXP (MAX_DEN_EXP)
    ) u_reduce (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (ctl_sr),
        .zn_in  (zn_sr),
        .e_in   (e_sr),
        .done   (done),
        .result (result)
    );

    // Every transfer in produces exactly one result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("result missing seven cycles after a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 7))
        else $error("result without a matching transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.kind == sdb_pkg::KIND_SWITCH) |->
        (result.z_num == '0 && result.z_den_exp == '0))
        else $error("switch result carries a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.kind == sdb_pkg::KIND_NUMBER && result.z_den_exp != '0) |->
        result.z_num[0])
        else $error("number result not in lowest terms");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.kind == sdb_pkg::KIND_NUMBER) |->
        (result.z_den_exp <= sdb_pkg::OUT_EXP_W'(MAX_DEN_EXP + 1)))
        else $error("number result exponent out of range");

endmodule
